@@ rtl/csrb_pkg.sv @@
// ----------------------------------------------------------------------------
// csrb_pkg
// shared types, codes and crc/startup-image helpers for the snapshot bridge
// ----------------------------------------------------------------------------
`default_nettype none

package csrb_pkg;

  typedef enum logic [1:0] {
    OP_SERIAL = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_FINISH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_ACCEPT = 2'd1,
    STAT_REJECT = 2'd2
  } frame_status_t;

  localparam int IDX_W  = 8;
  localparam int BANK_W = 2;
  localparam logic [BANK_W-1:0] BANK_BOOT = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h4E, 8'h41, 8'h56};

  // parser to top: one assembly write and the frame verdict
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    frame_status_t    status;
  } parse_out_t;

  // bus side to top
  typedef struct packed {
    logic latch;
    logic read;
    logic in_range;
    logic finish;
  } bus_out_t;

  // crc-16/ccitt-false over one byte, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // startup image without its crc bytes
  function automatic logic [7:0] boot_raw(input int i, input int len);
    logic [7:0] r;
    r = 8'h00;
    if (i < 4) begin
      r = MAGIC[2'(i)];
    end else if (i == 4) begin
      r = 8'h01;
    end else if (i == 5) begin
      r = 8'(len);
    end else if (i >= 32 && i < 40 && i < len - 2) begin
      r = 8'hFF;
    end
    return r;
  endfunction

  // crc of the startup image, evaluated at elaboration
  function automatic logic [15:0] boot_crc(input int len);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < len - 2; i++) begin
      c = crc16_byte(c, boot_raw(i, len));
    end
    return c;
  endfunction

  // full startup image byte
  function automatic logic [7:0] boot_byte(input logic [7:0] idx, input int len,
                                           input logic [15:0] crc);
    int i;
    logic [7:0] r;
    i = int'(idx);
    if (i == len - 2) begin
      r = crc[7:0];
    end else if (i == len - 1) begin
      r = crc[15:8];
    end else begin
      r = boot_raw(i, len);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/crc_framed_snapshot_register_bridge.sv @@
// ----------------------------------------------------------------------------
// crc_framed_snapshot_register_bridge
// serial frame receiver with crc check, snapshot publish and byte read port
// ----------------------------------------------------------------------------
// Every item (a serial byte or a bus write, read or finish event) gives exactly
// one result item, which moves from acceptance into the middle stage, which
// waits for the registered read of the snapshot ram, and from there into
// the output register. While results are taken a new
// item can be accepted every cycle; when the output stalls, one more item is
// taken into the middle stage and then the input stalls until the output
// moves. Assembled, published and latched frames live as three banks of one
// ram (3 * 2^ceil(log2 FRAME_LEN) bytes), so publishing a frame and latching
// the published one are bank-pointer swaps, not copies. After reset the
// published and latched banks point at the constant startup image, so no
// clearing pass is needed and items are accepted right away.
// expected_version sits at byte address 0 of the apb port and should only be
// written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_snapshot_register_bridge #(
  parameter int FRAME_LEN = 56
) (
  input  logic        clk,
  input  logic        rst,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [1:0]  frame_status,
  output logic [31:0] accepted_total,
  output logic [31:0] rejected_total,
  output logic [31:0] transaction_total
);

  import csrb_pkg::*;

  localparam int IW      = $clog2(FRAME_LEN);
  localparam int RamDepth = 3 * (2 ** IW);
  localparam logic [15:0] BootCrc = boot_crc(FRAME_LEN);
  localparam logic [2:0]  ADDR_EXPECTED_VERSION = 3'd0;

  // config register
  logic [7:0] expected_version;

  // handshake and decode
  opcode_t    op;
  logic       acc_in;
  logic       p_move;

  parse_out_t po;
  bus_out_t   bo;
  logic [7:0] ptr;

  // bank pointers: assembly, published, latched
  logic [BANK_W-1:0] bank_a;
  logic [BANK_W-1:0] bank_p;
  logic [BANK_W-1:0] bank_l;
  logic [BANK_W-1:0] bank_free;

  // counters
  logic [31:0] acc_cnt;
  logic [31:0] rej_cnt;
  logic [31:0] trn_cnt;

  // stage between acceptance and the output register
  logic          p_valid;
  frame_status_t p_status;
  logic          p_use_ram;
  logic [7:0]    p_rom;
  logic [7:0]    ram_rdata;
  logic          ram_re;

  frame_status_t out_status;

  assign op     = opcode_t'(opcode);
  assign p_move = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || p_move;
  assign acc_in = in_valid && in_ready;

  // apb: always ready, single register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_EXPECTED_VERSION) ? {24'h0, expected_version} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'h01;
    end else if (psel && penable && pwrite && paddr == ADDR_EXPECTED_VERSION) begin
      expected_version <= pwdata[7:0];
    end
  end

  csrb_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .take             (acc_in && op == OP_SERIAL),
    .data_byte        (data_byte),
    .expected_version (expected_version),
    .po               (po)
  );

  csrb_bus #(
    .FRAME_LEN(FRAME_LEN)
  ) u_bus (
    .clk       (clk),
    .rst       (rst),
    .ev        (acc_in && op != OP_SERIAL),
    .op        (op),
    .data_byte (data_byte),
    .ptr       (ptr),
    .bo        (bo)
  );

  // next assembly bank after a publish: any ram bank that is neither the
  // new published one (old assembly) nor the latched one
  always_comb begin
    if (bank_a != 2'd0 && bank_l != 2'd0) begin
      bank_free = 2'd0;
    end else if (bank_a != 2'd1 && bank_l != 2'd1) begin
      bank_free = 2'd1;
    end else begin
      bank_free = 2'd2;
    end
  end

  // read only ram banks; the startup image comes from the constant table
  assign ram_re = bo.read && bo.in_range && bank_l != BANK_BOOT;

  csrb_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk   (clk),
    .we    (po.wr_en),
    .waddr ({bank_a, po.wr_idx[IW-1:0]}),
    .wdata (po.wr_data),
    .re    (ram_re),
    .raddr ({bank_l, ptr[IW-1:0]}),
    .rdata (ram_rdata)
  );

  // bank swaps and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_a  <= 2'd0;
      bank_p  <= BANK_BOOT;
      bank_l  <= BANK_BOOT;
      acc_cnt <= '0;
      rej_cnt <= '0;
      trn_cnt <= '0;
    end else begin
      if (po.status == STAT_ACCEPT) begin
        bank_p  <= bank_a;
        bank_a  <= bank_free;
        acc_cnt <= acc_cnt + 32'd1;
      end
      if (po.status == STAT_REJECT) begin
        rej_cnt <= rej_cnt + 32'd1;
      end
      // latch the published snapshot for the read port
      if (bo.latch) begin
        bank_l <= bank_p;
      end
      if (bo.finish) begin
        trn_cnt <= trn_cnt + 32'd1;
      end
    end
  end

  // middle stage: waits for the registered ram read; counters need no copy
  // here since nothing new is accepted while this stage holds
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (acc_in) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
    if (acc_in) begin
      p_status  <= po.status;
      p_use_ram <= ram_re;
      p_rom     <= (bo.read && bo.in_range && bank_l == BANK_BOOT) ?
                   boot_byte(ptr, FRAME_LEN, BootCrc) : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (p_move) begin
      read_data         <= p_use_ram ? ram_rdata : p_rom;
      out_status        <= p_status;
      accepted_total    <= acc_cnt;
      rejected_total    <= rej_cnt;
      transaction_total <= trn_cnt;
    end
  end

  assign frame_status = out_status;

endmodule

`default_nettype wire

@@ rtl/csrb_ram.sv @@
// ----------------------------------------------------------------------------
// csrb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module csrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/csrb_parser.sv @@
// ----------------------------------------------------------------------------
// csrb_parser
// serial frame sync, header check and running crc for one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module csrb_parser #(
  parameter int FRAME_LEN = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           expected_version,
  output csrb_pkg::parse_out_t po
);

  import csrb_pkg::*;

  localparam int IdxW = $clog2(FRAME_LEN + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LEN - 1);
  localparam logic [IdxW-1:0] CrcEnd  = IdxW'(FRAME_LEN - 2);
  localparam logic [7:0]      LenByte = 8'(FRAME_LEN);

  logic [IdxW-1:0] idx, idx_next;
  logic [15:0]     crc, crc_next;
  logic [7:0]      ver_byte;
  logic [7:0]      len_byte;
  logic [7:0]      crc_lo;
  logic            restart;

  always_comb begin
    idx_next = idx;
    crc_next = crc;
    restart  = 1'b0;
    po       = '0;
    po.status = STAT_NONE;
    if (take) begin
      if (idx < IdxW'(4)) begin
        if (data_byte == MAGIC[idx[1:0]]) begin
          po.wr_en   = 1'b1;
          po.wr_idx  = IDX_W'(idx);
          po.wr_data = data_byte;
          crc_next   = crc16_byte((idx == '0) ? CRC_INIT : crc, data_byte);
          idx_next   = idx + 1'b1;
        end else begin
          restart = 1'b1;
        end
      end else if (idx == IdxW'(5) &&
                   (ver_byte != expected_version || data_byte != LenByte)) begin
        po.status = STAT_REJECT;
        restart   = 1'b1;
      end else begin
        po.wr_en   = 1'b1;
        po.wr_idx  = IDX_W'(idx);
        po.wr_data = data_byte;
        if (idx < CrcEnd) begin
          crc_next = crc16_byte(crc, data_byte);
        end
        idx_next = idx + 1'b1;
        if (idx == LastIdx) begin
          idx_next = '0;
          crc_next = CRC_INIT;
          if (ver_byte == expected_version && len_byte == LenByte &&
              {data_byte, crc_lo} == crc) begin
            po.status = STAT_ACCEPT;
          end else begin
            po.status = STAT_REJECT;
          end
        end
      end
      // drop the partial frame, an 'F' starts a new one
      if (restart) begin
        idx_next = '0;
        crc_next = CRC_INIT;
        if (data_byte == MAGIC[0]) begin
          po.wr_en   = 1'b1;
          po.wr_idx  = '0;
          po.wr_data = data_byte;
          crc_next   = crc16_byte(CRC_INIT, data_byte);
          idx_next   = IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= CRC_INIT;
    end else begin
      idx <= idx_next;
      crc <= crc_next;
    end
    if (take && idx == IdxW'(4)) begin
      ver_byte <= data_byte;
    end
    if (take && idx == IdxW'(5)) begin
      len_byte <= data_byte;
    end
    if (take && idx == CrcEnd) begin
      crc_lo <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/csrb_bus.sv @@
// ----------------------------------------------------------------------------
// csrb_bus
// register read port: byte pointer, pointer-written flag, bus events
// ----------------------------------------------------------------------------
`default_nettype none

module csrb_bus #(
  parameter int FRAME_LEN = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ev,
  input  csrb_pkg::opcode_t  op,
  input  logic [7:0]         data_byte,
  output logic [7:0]         ptr,
  output csrb_pkg::bus_out_t bo
);

  import csrb_pkg::*;

  logic       pset;
  logic [7:0] ptr_next;
  logic       pset_next;

  always_comb begin
    ptr_next    = ptr;
    pset_next   = pset;
    bo          = '0;
    bo.in_range = ({1'b0, ptr} < 9'(FRAME_LEN));
    if (ev) begin
      unique case (op)
        OP_WRITE: begin
          if (!pset) begin
            ptr_next  = data_byte;
            pset_next = 1'b1;
            bo.latch  = (data_byte == 8'h00);
          end
        end
        OP_READ: begin
          bo.read  = 1'b1;
          ptr_next = ptr + 8'd1;
        end
        OP_FINISH: begin
          pset_next = 1'b0;
          bo.finish = 1'b1;
        end
        OP_SERIAL: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      pset <= 1'b0;
    end else begin
      ptr  <= ptr_next;
      pset <= pset_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/crc_framed_snapshot_register_bridge_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_framed_snapshot_register_bridge_tb
// self-checking bench for the framed snapshot receiver and its byte read port
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the parser, the published and
// latched snapshots, the read pointer and the counters, and works out the
// result of every accepted item. Directed items hit the header and pointer
// corner cases; random traffic then mixes whole frames (good, spoiled crc,
// wrong version, wrong length, cut short) with bus transactions and noise,
// under four idling mixes and four expected_version settings.
// ----------------------------------------------------------------------------

module crc_framed_snapshot_register_bridge_tb;

  import csrb_pkg::*;

  localparam int          FRAME_BYTES = 56;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CCITT_POLY  = 16'h1021;
  localparam logic [7:0]  SYNC_F      = 8'h46;
  localparam logic [7:0]  SYNC_N      = 8'h4E;
  localparam logic [7:0]  SYNC_A      = 8'h41;
  localparam logic [7:0]  SYNC_V      = 8'h56;

  typedef struct packed {
    logic [7:0]    read_data;
    frame_status_t frame_status;
    logic [31:0]   accepted_total;
    logic [31:0]   rejected_total;
    logic [31:0]   transaction_total;
  } bridge_result_t;

  // bitwise msb-first crc-16/ccitt-false update
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CCITT_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(input int unsigned i);
    logic [7:0] r;
    case (i)
      0: r = SYNC_F;
      1: r = SYNC_N;
      2: r = SYNC_A;
      default: r = SYNC_V;
    endcase
    return r;
  endfunction

  class bridge_scoreboard;
    logic [7:0]     assembly [FRAME_BYTES];
    int unsigned    fill;
    logic [15:0]    crc_acc;
    logic [7:0]     published [FRAME_BYTES];
    logic [7:0]     latched [FRAME_BYTES];
    logic [7:0]     rd_ptr;
    bit             ptr_set;
    logic [31:0]    n_accepted;
    logic [31:0]    n_rejected;
    logic [31:0]    n_finished;
    logic [7:0]     version;
    bridge_result_t expected_q [$];
    int             errors;
    int             n_checked;

    // startup snapshot: sync word, version 1, length, ff run at 32..39, crc
    function new();
      logic [15:0] c;
      c = CRC_SEED;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        published[i] = 8'h00;
        assembly[i]  = 8'h00;
      end
      for (int i = 0; i < 4; i++) begin
        published[i] = sync_byte(i);
      end
      published[4] = 8'h01;
      published[5] = 8'(FRAME_BYTES);
      for (int i = 32; i < 40; i++) begin
        if (i < FRAME_BYTES - 2) begin
          published[i] = 8'hFF;
        end
      end
      for (int i = 0; i < FRAME_BYTES - 2; i++) begin
        c = crc16_fold(c, published[i]);
      end
      published[FRAME_BYTES-2] = c[7:0];
      published[FRAME_BYTES-1] = c[15:8];
      latched    = published;
      fill       = 0;
      crc_acc    = CRC_SEED;
      rd_ptr     = 8'h00;
      ptr_set    = 1'b0;
      n_accepted = '0;
      n_rejected = '0;
      n_finished = '0;
      version    = 8'h01;
      errors     = 0;
      n_checked  = 0;
    endfunction

    function void absorb(input logic [7:0] b);
      if (fill >= FRAME_BYTES) begin
        return;
      end
      assembly[fill] = b;
      if (fill < FRAME_BYTES - 2) begin
        crc_acc = crc16_fold((fill == 0) ? CRC_SEED : crc_acc, b);
      end
      fill++;
    endfunction

    // drop the partial frame, keeping an 'F' as a fresh start
    function void resync(input logic [7:0] b);
      fill    = 0;
      crc_acc = CRC_SEED;
      if (b == SYNC_F) begin
        absorb(b);
      end
    endfunction

    function frame_status_t parse_serial(input logic [7:0] b);
      logic [15:0] carried;
      bit          good;
      if (fill < 4) begin
        if (b == sync_byte(fill)) begin
          absorb(b);
        end else begin
          resync(b);
        end
        return STAT_NONE;
      end
      absorb(b);
      if (fill == 6 && (assembly[4] != version || assembly[5] != 8'(FRAME_BYTES))) begin
        n_rejected++;
        resync(b);
        return STAT_REJECT;
      end
      if (fill < FRAME_BYTES) begin
        return STAT_NONE;
      end
      carried = {assembly[FRAME_BYTES-1], assembly[FRAME_BYTES-2]};
      good = (assembly[4] == version) && (assembly[5] == 8'(FRAME_BYTES)) &&
             (carried == crc_acc);
      fill    = 0;
      crc_acc = CRC_SEED;
      if (good) begin
        published = assembly;
        n_accepted++;
        return STAT_ACCEPT;
      end
      n_rejected++;
      return STAT_REJECT;
    endfunction

    function void note_item(input opcode_t op, input logic [7:0] b);
      bridge_result_t r;
      r.read_data    = 8'h00;
      r.frame_status = STAT_NONE;
      case (op)
        OP_SERIAL: r.frame_status = parse_serial(b);
        OP_WRITE: begin
          if (!ptr_set) begin
            rd_ptr  = b;
            ptr_set = 1'b1;
            if (b == 8'h00) begin
              latched = published;
            end
          end
        end
        OP_READ: begin
          if (int'(rd_ptr) < FRAME_BYTES) begin
            r.read_data = latched[rd_ptr];
          end
          rd_ptr = rd_ptr + 8'd1;
        end
        default: begin
          ptr_set = 1'b0;
          n_finished++;
        end
      endcase
      r.accepted_total    = n_accepted;
      r.rejected_total    = n_rejected;
      r.transaction_total = n_finished;
      expected_q.push_back(r);
    endfunction

    function void check_result(input bridge_result_t got);
      bridge_result_t want;
      if (expected_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.read_data !== want.read_data) begin
        $error("read_data expected %0h got %0h", want.read_data, got.read_data);
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status expected %0d got %0d", want.frame_status, got.frame_status);
        errors++;
      end
      if (got.accepted_total !== want.accepted_total) begin
        $error("accepted_total expected %0h got %0h",
               want.accepted_total, got.accepted_total);
        errors++;
      end
      if (got.rejected_total !== want.rejected_total) begin
        $error("rejected_total expected %0h got %0h",
               want.rejected_total, got.rejected_total);
        errors++;
      end
      if (got.transaction_total !== want.transaction_total) begin
        $error("transaction_total expected %0h got %0h",
               want.transaction_total, got.transaction_total);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam logic [2:0] REG_EXPECTED_VERSION = 3'd0;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 4;     // extra wait once every result is back
  localparam int STALL_LIMIT     = 5000;  // cycles with nothing moving

  logic        clk;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode       = OP_SERIAL;
  logic [7:0]  data_byte    = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  read_data;
  logic [1:0]  frame_status;
  logic [31:0] accepted_total;
  logic [31:0] rejected_total;
  logic [31:0] transaction_total;

  bridge_scoreboard sb;

  // idling mix of the current phase, in percent
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;

  logic [7:0] phase_version [4];

  crc_framed_snapshot_register_bridge #(
    .FRAME_LEN(FRAME_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .read_data        (read_data),
    .frame_status     (frame_status),
    .accepted_total   (accepted_total),
    .rejected_total   (rejected_total),
    .transaction_total(transaction_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driving tasks: entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // offer one item, with a random gap in front of it, and hold it until taken
  task automatic send_item(input opcode_t op, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    sb.note_item(op, d);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of expected_version: setup cycle, then access cycle
  task automatic cfg_write_version(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_EXPECTED_VERSION;
    pwdata  <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.version = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // apb read back of expected_version against the scoreboard copy
  task automatic cfg_check_version();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_EXPECTED_VERSION;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== sb.version) begin
      $error("expected_version expected %0h got %0h", sb.version, prdata[7:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // one frame with random body; spoil flips a byte after the crc is computed,
  // stop_at cuts the frame short; a stray bus read may slip in between bytes
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] len_byte,
                            input bit spoil, input int stop_at);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] c;
    int          k;
    c = CRC_SEED;
    for (k = 0; k < 4; k++) begin
      fr[k] = sync_byte(k);
    end
    fr[4] = ver;
    fr[5] = len_byte;
    for (k = 6; k < FRAME_BYTES - 2; k++) begin
      fr[k] = 8'($urandom);
    end
    for (k = 0; k < FRAME_BYTES - 2; k++) begin
      c = crc16_fold(c, fr[k]);
    end
    fr[FRAME_BYTES-2] = c[7:0];
    fr[FRAME_BYTES-1] = c[15:8];
    if (spoil) begin
      k = $urandom_range(6, FRAME_BYTES - 1);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < stop_at; k++) begin
      if ($urandom_range(19) == 0) begin
        send_item(OP_READ, 8'($urandom));
      end
      send_item(OP_SERIAL, fr[k]);
    end
  endtask

  // pointer write (zero latches the snapshot), reads, usually a finish
  task automatic send_bus_transaction();
    logic [7:0] p;
    int         sel;
    int         n;
    sel = $urandom_range(9);
    if (sel < 4) begin
      p = 8'h00;
    end else if (sel < 6) begin
      p = 8'($urandom_range(0, FRAME_BYTES - 1));
    end else if (sel == 6) begin
      p = 8'($urandom_range(250, 255));
    end else if (sel == 7) begin
      p = 8'($urandom_range(FRAME_BYTES - 3, FRAME_BYTES + 2));
    end else begin
      p = 8'($urandom);
    end
    send_item(OP_WRITE, p);
    if ($urandom_range(3) == 0) begin
      send_item(OP_WRITE, 8'($urandom));  // ignored while the pointer is set
    end
    n = $urandom_range(1, 8);
    repeat (n) send_item(OP_READ, 8'($urandom));
    if ($urandom_range(9) != 0) begin
      send_item(OP_FINISH, 8'($urandom));
    end
  endtask

  // random opcodes, serial bytes leaning toward the sync characters
  task automatic send_noise();
    int         n;
    logic [7:0] d;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(1) == 0) begin
        d = sync_byte($urandom_range(3));
      end else begin
        d = 8'($urandom);
      end
      send_item(opcode_t'($urandom_range(3)), d);
    end
  endtask

  task automatic send_random_chunk(input logic [7:0] v);
    int sel;
    int kind;
    sel = $urandom_range(99);
    if (sel < 50) begin
      kind = $urandom_range(9);
      if ($urandom_range(3) == 0) begin
        send_noise();
      end
      case (kind)
        0: send_frame(v ^ 8'($urandom_range(1, 255)), 8'(FRAME_BYTES), 1'b0, FRAME_BYTES);
        1: send_frame(v, 8'(FRAME_BYTES) ^ 8'($urandom_range(1, 255)), 1'b0, FRAME_BYTES);
        2, 3: send_frame(v, 8'(FRAME_BYTES), 1'b1, FRAME_BYTES);
        4: send_frame(v, 8'(FRAME_BYTES), 1'b0, $urandom_range(1, FRAME_BYTES - 1));
        default: send_frame(v, 8'(FRAME_BYTES), 1'b0, FRAME_BYTES);
      endcase
    end else if (sel < 85) begin
      send_bus_transaction();
    end else begin
      send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    bridge_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.read_data         = read_data;
      got.frame_status      = frame_status_t'(frame_status);
      got.accepted_total    = accepted_total;
      got.rejected_total    = rejected_total;
      got.transaction_total = transaction_total;
      sb.check_result(got);
    end
  end

  // watchdog: ends the run if no item moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int target;
    int midpoint;
    bit mid_done;
    sb = new();
    phase_version[0] = 8'h00;
    phase_version[1] = 8'hFF;
    phase_version[2] = 8'h01;
    phase_version[3] = 8'($urandom_range(2, 254));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value first, then an explicit write of the same
    cfg_check_version();
    cfg_write_version(8'h01);
    cfg_check_version();

    // directed: pointer corners against the startup snapshot
    send_item(OP_WRITE, 8'd31);
    send_item(OP_READ, 8'h00);                 // last zero before the ff run
    send_item(OP_READ, 8'hFF);                 // first ff byte
    send_item(OP_WRITE, 8'd99);                // repeated write, ignored
    send_item(OP_FINISH, 8'h00);
    send_item(OP_WRITE, 8'hFF);
    send_item(OP_READ, 8'h5A);                 // beyond the frame reads zero
    send_item(OP_READ, 8'hA5);                 // pointer wrapped to zero
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_WRITE, 8'(FRAME_BYTES - 1));
    send_item(OP_READ, 8'h00);                 // crc high byte
    send_item(OP_READ, 8'h00);                 // one past the end
    send_item(OP_FINISH, 8'h00);
    // directed: sync hunting and a bad length byte
    send_item(OP_SERIAL, SYNC_F);
    send_item(OP_SERIAL, SYNC_N);
    send_item(OP_SERIAL, 8'h58);               // sync mismatch
    send_item(OP_SERIAL, SYNC_F);
    send_item(OP_SERIAL, SYNC_F);              // repeated 'F' restarts the hunt
    send_item(OP_SERIAL, SYNC_N);
    send_item(OP_SERIAL, SYNC_A);
    send_item(OP_SERIAL, SYNC_V);
    send_item(OP_SERIAL, 8'h01);
    send_item(OP_SERIAL, SYNC_F);              // wrong length, 'F' kept as start

    // random phases: each with its own idling mix and version setting
    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      cfg_write_version(phase_version[ph]);
      cfg_check_version();
      target   = items_sent + ITEMS_PER_PHASE;
      midpoint = items_sent + ITEMS_PER_PHASE / 2;
      mid_done = 1'b0;
      while (items_sent < target) begin
        if (!mid_done && items_sent >= midpoint) begin
          mid_done = 1'b1;
          if (ph == 0) begin
            hold_request = 1'b1;   // receiver backs off while the sender keeps going
          end else if (ph == 1) begin
            drain();               // sender pauses until everything has come back
          end
        end
        send_random_chunk(phase_version[ph]);
      end
    end

    drain();
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end

    $display("%0d items over four idling mixes, expected_version %0h/%0h/%0h/%0h",
             items_sent, phase_version[0], phase_version[1], phase_version[2],
             phase_version[3]);
    $display("%0d results checked: %0d frames accepted, %0d rejected, %0d transactions",
             sb.n_checked, sb.n_accepted, sb.n_rejected, sb.n_finished);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
